[rtl/cdsr_pkg.sv]
package cdsr_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_DUTY      = 3'd0;
    localparam logic [2:0] CFG_MAX_DUTY      = 3'd1;
    localparam logic [2:0] CFG_MAX_CURRENT   = 3'd2;
    localparam logic [2:0] CFG_MIN_VOLTAGE   = 3'd3;
    localparam logic [2:0] CFG_CRITICAL_TEMP = 3'd4;
    localparam logic [2:0] CFG_RAMP_DIVIDER  = 3'd5;
    localparam logic [2:0] CFG_PWM_PERIOD    = 3'd6;

    // configuration reset values
    localparam logic [6:0]  RST_MIN_DUTY      = 7'd10;
    localparam logic [6:0]  RST_MAX_DUTY      = 7'd90;
    localparam logic [7:0]  RST_MAX_CURRENT   = 8'd100;
    localparam logic [7:0]  RST_MIN_VOLTAGE   = 8'd30;
    localparam logic [7:0]  RST_CRITICAL_TEMP = 8'd60;
    localparam logic [7:0]  RST_RAMP_DIVIDER  = 8'd3;
    localparam logic [15:0] RST_PWM_PERIOD    = 16'd250;

    // duty constants
    localparam logic [6:0] DUTY_FULL    = 7'd100;
    localparam logic [8:0] RAMP_MARGIN  = 9'd5;
    localparam logic [6:0] BACKOFF_STEP = 7'd2;

    // divide by 100 as multiply by reciprocal, exact for products below 2^23
    localparam int          DIV_SHIFT = 30;
    localparam logic [23:0] DIV_MULT  = 24'd10737419;
    localparam int          PROD_W    = 23;

    typedef struct packed {
        logic [6:0]  min_duty;
        logic [6:0]  max_duty;
        logic [7:0]  max_current;
        logic [7:0]  min_voltage;
        logic [7:0]  critical_temp;
        logic [7:0]  ramp_divider;
        logic [15:0] pwm_period;
    } t_cfg;

    typedef struct packed {
        logic [7:0] request_duty;
        logic       on_switch;
        logic       deadman_switch;
        logic [7:0] current_level;
        logic [7:0] voltage_level;
        logic [7:0] temperature_level;
    } t_in;

    typedef struct packed {
        logic [6:0]  duty_now;
        logic [15:0] compare_level;
        logic        running;
        logic        drive_gate;
        logic        full_on;
        logic        temp_warning;
    } t_out;

    // control stage result handed to the compare scaler
    typedef struct packed {
        logic [6:0] duty_now;
        logic       running;
        logic       drive_gate;
        logic       full_on;
        logic       temp_warning;
        logic [6:0] cmp_arg;
        logic       cmp_upd;
    } t_ctrl_res;

endpackage

[rtl/cdsr_ctrl.sv]
module cdsr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdsr_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  cdsr_pkg::t_in      i_item,
    output logic               o_stall,
    output logic               o_valid,
    output cdsr_pkg::t_ctrl_res o_res,
    input  logic               i_ready
);

    typedef struct packed {
        logic [6:0] duty;
        logic       upd;
    } t_set;

    // duty setter: clamp below min to zero, above max to full
    function automatic t_set f_set(input logic [7:0] v, input logic [6:0] mn,
                                   input logic [6:0] mx);
        t_set s;
        s.upd = 1'b0;
        if (v < {1'b0, mn}) begin
            s.duty = '0;
        end else if (v > {1'b0, mx}) begin
            s.duty = cdsr_pkg::DUTY_FULL;
        end else begin
            s.duty = v[6:0];
            s.upd  = 1'b1;
        end
        return s;
    endfunction

    logic [6:0] r_duty;
    logic       r_run;
    logic [7:0] r_rc;
    logic       r_warn;
    logic       r_valid;
    cdsr_pkg::t_ctrl_res r_res;

    logic [6:0] n_duty;
    logic       n_run;
    logic [7:0] n_rc;
    logic       n_warn;
    cdsr_pkg::t_ctrl_res n_res;

    logic       ready_a;
    logic       accept;
    logic       both_on;
    logic [7:0] req;
    logic [6:0] d1;
    logic [7:0] ramp_arg;
    logic [7:0] back_arg;
    logic       req_hi;
    t_set       s1;
    t_set       s2;

    assign ready_a = !r_valid || i_ready;
    assign accept  = i_valid && ready_a;
    assign o_stall = !ready_a;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // one tick of the duty controller
    always_comb begin
        both_on  = i_item.on_switch && i_item.deadman_switch;
        req      = i_item.request_duty;
        req_hi   = {1'b0, req} > ({2'b0, i_cfg.min_duty} + cdsr_pkg::RAMP_MARGIN);
        ramp_arg = (r_duty == 7'd0) ? {1'b0, i_cfg.min_duty} : ({1'b0, r_duty} + 8'd1);
        n_rc     = r_rc;
        s1.duty  = r_duty;
        s1.upd   = 1'b0;
        s2       = '0;

        // run latch
        if (!both_on) begin
            n_run = 1'b0;
        end else if (req < {1'b0, i_cfg.min_duty} && !r_run) begin
            n_run = 1'b1;
        end else begin
            n_run = r_run;
        end

        // soft-start ramp, immediate follow down, drive off
        if (n_run) begin
            if ({1'b0, r_duty} != req) begin
                if (req > {1'b0, r_duty} && req_hi) begin
                    if (r_rc == i_cfg.ramp_divider) begin
                        s1   = f_set(ramp_arg, i_cfg.min_duty, i_cfg.max_duty);
                        n_rc = '0;
                    end else begin
                        n_rc = r_rc + 8'd1;
                    end
                end else if (req < {1'b0, r_duty}) begin
                    s1 = f_set(req, i_cfg.min_duty, i_cfg.max_duty);
                end
            end
        end else if (r_duty != 7'd0) begin
            s1 = f_set(8'd0, i_cfg.min_duty, i_cfg.max_duty);
        end
        d1 = s1.duty;

        // over-current or under-voltage back-off
        if (d1 == cdsr_pkg::DUTY_FULL) begin
            back_arg = {1'b0, i_cfg.max_duty};
        end else if (d1 < cdsr_pkg::BACKOFF_STEP) begin
            back_arg = '0;
        end else begin
            back_arg = {1'b0, d1 - cdsr_pkg::BACKOFF_STEP};
        end
        n_duty = d1;
        if (d1 >= i_cfg.min_duty && (i_item.current_level > i_cfg.max_current
                || i_item.voltage_level < i_cfg.min_voltage)) begin
            s2     = f_set(back_arg, i_cfg.min_duty, i_cfg.max_duty);
            n_duty = s2.duty;
        end

        // temperature warning with hold at threshold
        if (i_item.temperature_level > i_cfg.critical_temp) begin
            n_warn = 1'b1;
        end else if (i_item.temperature_level < i_cfg.critical_temp) begin
            n_warn = 1'b0;
        end else begin
            n_warn = r_warn;
        end

        // result item, compare argument from the last in-band setting
        n_res.duty_now     = n_duty;
        n_res.running      = n_run;
        n_res.drive_gate   = (n_duty != 7'd0) && both_on;
        n_res.full_on      = (n_duty == cdsr_pkg::DUTY_FULL);
        n_res.temp_warning = n_warn;
        n_res.cmp_upd      = s1.upd || s2.upd;
        n_res.cmp_arg      = s2.upd ? s2.duty : s1.duty;
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= '0;
            r_run  <= 1'b0;
            r_rc   <= '0;
            r_warn <= 1'b0;
        end else if (accept) begin
            r_duty <= n_duty;
            r_run  <= n_run;
            r_rc   <= n_rc;
            r_warn <= n_warn;
        end
    end

    // stage register toward the scaler
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready_a) begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

endmodule

[rtl/cdsr_scale.sv]
module cdsr_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_period,
    input  logic                i_valid,
    input  cdsr_pkg::t_ctrl_res i_res,
    output logic                o_ready,
    output logic                o_valid,
    output cdsr_pkg::t_out      o_item,
    input  logic                i_stall
);

    localparam int QW = 2 * cdsr_pkg::PROD_W + 1 - cdsr_pkg::DIV_SHIFT;

    logic                               r_vb;
    logic [cdsr_pkg::PROD_W-1:0]        r_prod;
    cdsr_pkg::t_ctrl_res                r_res_b;
    logic                               r_vc;
    cdsr_pkg::t_out                     r_out;
    logic [15:0]                        r_cmp;

    logic                               ready_b;
    logic                               ready_c;
    logic [cdsr_pkg::PROD_W+23:0]       recip;
    logic [QW-1:0]                      quot;
    logic [15:0]                        sat;
    logic [15:0]                        n_cmp;

    assign ready_c = !r_vc || !i_stall;
    assign ready_b = !r_vb || ready_c;
    assign o_ready = ready_b;
    assign o_valid = r_vc;
    assign o_item  = r_out;

    // stage b: duty times period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ready_b) begin
            r_vb <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_prod  <= cdsr_pkg::PROD_W'({16'd0, i_res.cmp_arg} * {7'd0, i_period});
            r_res_b <= i_res;
        end
    end

    // stage c: divide by 100 through the reciprocal, saturate to 16 bits
    always_comb begin
        recip = {24'd0, r_prod} * {{cdsr_pkg::PROD_W{1'b0}}, cdsr_pkg::DIV_MULT};
        quot  = recip[cdsr_pkg::DIV_SHIFT +: QW];
        sat   = (quot[QW-1:16] != '0) ? 16'hFFFF : quot[15:0];
        n_cmp = r_res_b.cmp_upd ? sat : r_cmp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc  <= 1'b0;
            r_cmp <= '0;
        end else if (ready_c) begin
            r_vc <= r_vb;
            if (r_vb) begin
                r_cmp <= n_cmp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_vb) begin
            r_out.duty_now      <= r_res_b.duty_now;
            r_out.compare_level <= n_cmp;
            r_out.running       <= r_res_b.running;
            r_out.drive_gate    <= r_res_b.drive_gate;
            r_out.full_on       <= r_res_b.full_on;
            r_out.temp_warning  <= r_res_b.temp_warning;
        end
    end

endmodule

[rtl/chopper_duty_soft_start_ramp.sv]
// path: an accepted input item passes the control stage register, stage b and the output register
// throughput: one item per cycle while the output is not stalled; duty, run latch and ramp state update per item
// the compare level follows through a multiply stage and a reciprocal-multiply stage
// reset: synchronous active low; clears duty, compare level, run latch, ramp count,
// warning flag and all stage valids, and loads the configuration defaults
module chopper_duty_soft_start_ramp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cdsr_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cdsr_pkg::t_out o_out_item,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);

    cdsr_pkg::t_cfg      r_cfg;
    logic                a_valid;
    cdsr_pkg::t_ctrl_res a_res;
    logic                b_ready;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_duty      <= cdsr_pkg::RST_MIN_DUTY;
            r_cfg.max_duty      <= cdsr_pkg::RST_MAX_DUTY;
            r_cfg.max_current   <= cdsr_pkg::RST_MAX_CURRENT;
            r_cfg.min_voltage   <= cdsr_pkg::RST_MIN_VOLTAGE;
            r_cfg.critical_temp <= cdsr_pkg::RST_CRITICAL_TEMP;
            r_cfg.ramp_divider  <= cdsr_pkg::RST_RAMP_DIVIDER;
            r_cfg.pwm_period    <= cdsr_pkg::RST_PWM_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cdsr_pkg::CFG_MIN_DUTY:      r_cfg.min_duty      <= i_cfg_data[6:0];
                cdsr_pkg::CFG_MAX_DUTY:      r_cfg.max_duty      <= i_cfg_data[6:0];
                cdsr_pkg::CFG_MAX_CURRENT:   r_cfg.max_current   <= i_cfg_data[7:0];
                cdsr_pkg::CFG_MIN_VOLTAGE:   r_cfg.min_voltage   <= i_cfg_data[7:0];
                cdsr_pkg::CFG_CRITICAL_TEMP: r_cfg.critical_temp <= i_cfg_data[7:0];
                cdsr_pkg::CFG_RAMP_DIVIDER:  r_cfg.ramp_divider  <= i_cfg_data[7:0];
                cdsr_pkg::CFG_PWM_PERIOD:    r_cfg.pwm_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // duty controller
    cdsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_valid (a_valid),
        .o_res   (a_res),
        .i_ready (b_ready)
    );

    // compare level scaler and output register
    cdsr_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_cfg.pwm_period),
        .i_valid  (a_valid),
        .i_res    (a_res),
        .o_ready  (b_ready),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .i_stall  (i_out_stall)
    );

endmodule

[rtl/cdsr_checker.sv]
module cdsr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input cdsr_pkg::t_out o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // full on flag matches the duty
    a_full_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.full_on == (o_out_item.duty_now == 7'd100)))
        else $error("full_on disagrees with duty_now");

    // the gate drives only with nonzero duty and an armed run latch
    a_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.drive_gate |->
            o_out_item.running && (o_out_item.duty_now != 7'd0))
        else $error("drive_gate without run latch or duty");

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // with the output side free the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !i_out_stall |-> !o_in_stall)
        else $error("input stalled with an empty pipeline exit");

endmodule

bind chopper_duty_soft_start_ramp cdsr_checker u_cdsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
